@@ design/adk_pkg.sv @@
`timescale 1ns / 1ps
// adk_pkg: shared types and constants for the escape key decoder
// no dependencies; used by every design file except adk_if

package adk_pkg;

	localparam int unsigned MaxEvents    = 4;
	localparam int unsigned FifoDepthDef = 4;
	localparam int unsigned AddrWidth    = 5;
	localparam int unsigned DataWidth    = 32;

	localparam logic [7:0] ESC_BYTE    = 8'd27;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_O        = 8'h4F;
	localparam logic [7:0] CH_TILDE    = 8'h7E;
	localparam logic [7:0] CH_ARROW_LO = 8'd65;
	localparam logic [7:0] CH_ARROW_HI = 8'd68;
	localparam logic [7:0] CH_DIG_2    = 8'd50;
	localparam logic [7:0] CH_DIG_3    = 8'd51;
	localparam logic [7:0] CH_DIG_5    = 8'd53;
	localparam logic [7:0] CH_DIG_6    = 8'd54;
	localparam logic [7:0] CH_FKEY_LO  = 8'd80;
	localparam logic [7:0] CH_FKEY_HI  = 8'd83;
	localparam logic [7:0] CH_HOME     = 8'd72;
	localparam logic [7:0] CH_END      = 8'd70;

	localparam logic [7:0] RST_ESC_CODE   = 8'd27;
	localparam logic [7:0] RST_ENTER_CODE = 8'd13;
	localparam logic [7:0] RST_TAB_CODE   = 8'd9;
	localparam logic [7:0] RST_BS_CODE    = 8'd8;

	typedef enum logic [2:0] {
		REG_ENABLE   = 3'd0,
		REG_ESC_CODE = 3'd1,
		REG_ENTER    = 3'd2,
		REG_TAB      = 3'd3,
		REG_BS       = 3'd4
	} reg_idx_t;

	localparam logic CMD_BYTE    = 1'b0;
	localparam logic CMD_TIMEOUT = 1'b1;

	typedef enum logic [2:0] {
		ST_GROUND = 3'd0,
		ST_ESC    = 3'd1,
		ST_BR     = 3'd2,
		ST_O      = 3'd3,
		ST_TILDE  = 3'd4
	} parse_state_t;

	typedef struct packed {
		logic       enable;
		logic [7:0] esc_code;
		logic [7:0] enter_code;
		logic [7:0] tab_code;
		logic [7:0] bs_code;
	} cfg_t;

	typedef struct packed {
		logic [7:0] code;
		logic       special;
	} key_ev_t;

	typedef struct packed {
		logic [2:0]                    cnt;
		key_ev_t [MaxEvents-1:0]       ev;
	} job_t;

endpackage

@@ design/adk_if.sv @@
`timescale 1ns / 1ps
// key_in_if and key_out_if: valid/ready channels for input and result transactions
// no dependencies

interface key_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] key_byte;

	modport source (output valid, output cmd, output key_byte, input ready);
	modport sink (input valid, input cmd, input key_byte, output ready);
endinterface

interface key_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_code;
	logic       special;
	logic       last;

	modport source (output valid, output key_code, output special, output last, input ready);
	modport sink (input valid, input key_code, input special, input last, output ready);
endinterface

@@ design/adk_regs.sv @@
`timescale 1ns / 1ps
// adk_regs: apb configuration registers of the escape key decoder
// depends on adk_pkg

module adk_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [adk_pkg::AddrWidth-1:0]      paddr,
	input  logic [adk_pkg::DataWidth-1:0]      pwdata,
	output logic [adk_pkg::DataWidth-1:0]      prdata,
	output logic                               pready,
	output adk_pkg::cfg_t                      cfg
);
	import adk_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable     <= 1'b0;
			cfg_q.esc_code   <= RST_ESC_CODE;
			cfg_q.enter_code <= RST_ENTER_CODE;
			cfg_q.tab_code   <= RST_TAB_CODE;
			cfg_q.bs_code    <= RST_BS_CODE;
		end else if (wr_en) begin
			case (idx)
				REG_ENABLE:   cfg_q.enable     <= pwdata[0];
				REG_ESC_CODE: cfg_q.esc_code   <= pwdata[7:0];
				REG_ENTER:    cfg_q.enter_code <= pwdata[7:0];
				REG_TAB:      cfg_q.tab_code   <= pwdata[7:0];
				REG_BS:       cfg_q.bs_code    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_ENABLE:   prdata[0]   = cfg_q.enable;
			REG_ESC_CODE: prdata[7:0] = cfg_q.esc_code;
			REG_ENTER:    prdata[7:0] = cfg_q.enter_code;
			REG_TAB:      prdata[7:0] = cfg_q.tab_code;
			REG_BS:       prdata[7:0] = cfg_q.bs_code;
			default:      prdata      = '0;
		endcase
	end

endmodule

@@ design/adk_front.sv @@
`timescale 1ns / 1ps
// adk_front: sequence parser; turns each input transaction into at most one job of key events
// depends on adk_pkg and key_in_if

module adk_front (
	input  logic          clk,
	input  logic          arst_n,
	key_in_if.sink        key_in,
	input  adk_pkg::cfg_t cfg,
	input  logic          full,
	output logic          push,
	output adk_pkg::job_t job
);
	import adk_pkg::*;

	parse_state_t state_q, state_d;
	logic [7:0]   digit_q, digit_d;

	logic         accept;
	logic [7:0]   c;
	key_ev_t [2:0] ab_ev;
	logic [1:0]   n_ab;
	key_ev_t      g_ev;
	logic         do_ab, do_gnd;
	logic [1:0]   pos;

	assign key_in.ready = !full;
	assign accept       = key_in.valid && !full;
	assign c            = key_in.key_byte;

	// replay list for a broken-off sequence
	always_comb begin
		ab_ev = '0;
		n_ab  = 2'd0;
		case (state_q)
			ST_ESC: begin
				ab_ev[0] = '{code: cfg.esc_code, special: 1'b1};
				n_ab     = 2'd1;
			end
			ST_BR: begin
				ab_ev[0] = '{code: cfg.esc_code, special: 1'b1};
				ab_ev[1] = '{code: CH_LBRACKET, special: 1'b0};
				n_ab     = 2'd2;
			end
			ST_O: begin
				ab_ev[0] = '{code: cfg.esc_code, special: 1'b1};
				ab_ev[1] = '{code: CH_O, special: 1'b0};
				n_ab     = 2'd2;
			end
			ST_TILDE: begin
				ab_ev[0] = '{code: cfg.esc_code, special: 1'b1};
				ab_ev[1] = '{code: CH_LBRACKET, special: 1'b0};
				ab_ev[2] = '{code: digit_q, special: 1'b0};
				n_ab     = 2'd3;
			end
			default: begin
				ab_ev = '0;
				n_ab  = 2'd0;
			end
		endcase
	end

	assign g_ev.code    = c;
	assign g_ev.special = (c == cfg.enter_code) || (c == cfg.tab_code) || (c == cfg.bs_code);

	always_comb begin
		state_d = state_q;
		digit_d = digit_q;
		job     = '0;
		do_ab   = 1'b0;
		do_gnd  = 1'b0;
		pos     = 2'd0;
		if (cfg.enable) begin
			if (key_in.cmd == CMD_TIMEOUT) begin
				do_ab   = 1'b1;
				state_d = ST_GROUND;
			end else begin
				case (state_q)
					ST_ESC: begin
						if (c == CH_LBRACKET) begin
							state_d = ST_BR;
						end else if (c == CH_O) begin
							state_d = ST_O;
						end else begin
							do_ab  = 1'b1;
							do_gnd = 1'b1;
						end
					end
					ST_BR: begin
						if (c inside {[CH_ARROW_LO:CH_ARROW_HI]}) begin
							job.ev[0] = '{code: c, special: 1'b1};
							job.cnt   = 3'd1;
							state_d   = ST_GROUND;
						end else if (c inside {CH_DIG_2, CH_DIG_3, CH_DIG_5, CH_DIG_6}) begin
							digit_d = c;
							state_d = ST_TILDE;
						end else begin
							do_ab  = 1'b1;
							do_gnd = 1'b1;
						end
					end
					ST_O: begin
						if (c inside {[CH_FKEY_LO:CH_FKEY_HI], CH_HOME, CH_END}) begin
							job.ev[0] = '{code: c, special: 1'b1};
							job.cnt   = 3'd1;
							state_d   = ST_GROUND;
						end else begin
							do_ab  = 1'b1;
							do_gnd = 1'b1;
						end
					end
					ST_TILDE: begin
						if (c == CH_TILDE) begin
							job.ev[0] = '{code: digit_q, special: 1'b1};
							job.cnt   = 3'd1;
							state_d   = ST_GROUND;
						end else begin
							do_ab  = 1'b1;
							do_gnd = 1'b1;
						end
					end
					default: begin
						do_gnd = 1'b1;
					end
				endcase
			end
			if (do_ab) begin
				job.ev[2:0] = ab_ev;
				job.cnt     = {1'b0, n_ab};
				pos         = n_ab;
				state_d     = ST_GROUND;
			end
			if (do_gnd) begin
				if (c == ESC_BYTE) begin
					state_d = ST_ESC;
				end else begin
					state_d     = ST_GROUND;
					job.ev[pos] = g_ev;
					job.cnt     = {1'b0, pos} + 3'd1;
				end
			end
		end
	end

	assign push = accept && (job.cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_GROUND;
			digit_q <= '0;
		end else if (accept) begin
			state_q <= state_d;
			digit_q <= digit_d;
		end
	end

endmodule

@@ design/adk_fifo.sv @@
`timescale 1ns / 1ps
// adk_fifo: short job queue between parser and event emitter
// depends on adk_pkg

module adk_fifo #(
	parameter int unsigned Depth = adk_pkg::FifoDepthDef
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  adk_pkg::job_t wr_job,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output adk_pkg::job_t rd_job
);
	import adk_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	job_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_push, do_pop;

	assign full    = cnt_q == CntW'(Depth);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_job  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ design/adk_back.sv @@
`timescale 1ns / 1ps
// adk_back: emits the key events of the head job one per cycle while key_out.ready is high
// depends on adk_pkg and key_out_if

module adk_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  adk_pkg::job_t head,
	output logic          pop,
	key_out_if.source     key_out
);
	import adk_pkg::*;

	logic [1:0] idx_q;
	logic       is_last;
	logic       fire;
	key_ev_t    cur;

	assign cur              = head.ev[idx_q];
	assign is_last          = ({1'b0, idx_q} + 3'd1) == head.cnt;
	assign key_out.valid    = !empty;
	assign key_out.key_code = cur.code;
	assign key_out.special  = cur.special;
	assign key_out.last     = is_last;
	assign fire             = key_out.valid && key_out.ready;
	assign pop              = fire && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (fire) begin
			idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

@@ design/ansi_escape_key_decoder.sv @@
`timescale 1ns / 1ps
// ansi_escape_key_decoder: top level; parser, job queue, event emitter, apb registers
// depends on adk_pkg, key_in_if, key_out_if and the adk_* modules
//
// channel   dir  handshake      payload
// key_in    in   valid/ready    cmd, key_byte
// key_out   out  valid/ready    key_code, special, last
// apb       in   psel/penable   paddr, pwdata -> prdata
//
// one input transaction per cycle enters the parser while the job queue has room
// each job gives 1 to 4 result transactions, one per cycle while key_out.ready is high, from the head of the queue
// inputs that give no result put nothing in the queue
// a stalled output fills the queue, then key_in.ready drops
// reset: parser in ground state, queue empty, registers at their defaults

module ansi_escape_key_decoder #(
	parameter int unsigned FifoDepth = adk_pkg::FifoDepthDef
) (
	input  logic                           clk,
	input  logic                           arst_n,
	key_in_if.sink                         key_in,
	key_out_if.source                      key_out,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [adk_pkg::AddrWidth-1:0]  paddr,
	input  logic [adk_pkg::DataWidth-1:0]  pwdata,
	output logic [adk_pkg::DataWidth-1:0]  prdata,
	output logic                           pready
);
	import adk_pkg::*;

	cfg_t cfg;
	job_t wr_job, rd_job;
	logic push, pop, full, empty;

	adk_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	adk_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.key_in (key_in),
		.cfg    (cfg),
		.full   (full),
		.push   (push),
		.job    (wr_job)
	);

	adk_fifo #(
		.Depth (FifoDepth)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.rd_job (rd_job)
	);

	adk_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (empty),
		.head    (rd_job),
		.pop     (pop),
		.key_out (key_out)
	);

endmodule

@@ tb/key_event_checker.sv @@
`timescale 1ns / 1ps
// key_event_checker: follows the register port and the key channels, predicts the key
// events of every input transaction and compares them with the result transactions
// depends on adk_pkg, key_in_if and key_out_if

module key_event_checker
	import adk_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	key_in_if                    key_in,
	key_out_if                   key_out,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic                 pready,
	input  logic [AddrWidth-1:0] paddr,
	input  logic [DataWidth-1:0] pwdata,
	output int                   error_count,
	output int                   outstanding
);

	typedef struct packed {
		logic [7:0] code;
		logic       special;
		logic       last;
	} key_result_t;

	logic         cfg_enable;
	logic [7:0]   cfg_esc_code;
	logic [7:0]   cfg_enter;
	logic [7:0]   cfg_tab;
	logic [7:0]   cfg_bs;
	parse_state_t parse_st;
	logic [7:0]   held_digit;
	key_ev_t      step_events[$];
	key_result_t  expected_key_events[$];
	int           errors;

	function automatic void emit_key(input logic [7:0] code, input logic special);
		key_ev_t ev;
		ev.code = code;
		ev.special = special;
		if (step_events.size() < MaxEvents)
			step_events.push_back(ev);
	endfunction

	// broken sequence: escape event, then the consumed characters as plain
	function automatic void replay_broken_sequence();
		case (parse_st)
			ST_ESC: emit_key(cfg_esc_code, 1'b1);
			ST_BR: begin
				emit_key(cfg_esc_code, 1'b1);
				emit_key(CH_LBRACKET, 1'b0);
			end
			ST_O: begin
				emit_key(cfg_esc_code, 1'b1);
				emit_key(CH_O, 1'b0);
			end
			ST_TILDE: begin
				emit_key(cfg_esc_code, 1'b1);
				emit_key(CH_LBRACKET, 1'b0);
				emit_key(held_digit, 1'b0);
			end
			default: ;
		endcase
		parse_st = ST_GROUND;
	endfunction

	function automatic void take_ground_byte(input logic [7:0] c);
		if (c == ESC_BYTE)
			parse_st = ST_ESC;
		else
			emit_key(c, c == cfg_enter || c == cfg_tab || c == cfg_bs);
	endfunction

	function automatic void decode_key_transaction(input logic cmd, input logic [7:0] c);
		key_result_t res;
		step_events.delete();
		if (!cfg_enable)
			return;
		if (cmd == CMD_TIMEOUT) begin
			replay_broken_sequence();
		end else begin
			case (parse_st)
				ST_ESC: begin
					if (c == CH_LBRACKET)
						parse_st = ST_BR;
					else if (c == CH_O)
						parse_st = ST_O;
					else begin
						replay_broken_sequence();
						take_ground_byte(c);
					end
				end
				ST_BR: begin
					if (c >= CH_ARROW_LO && c <= CH_ARROW_HI) begin
						emit_key(c, 1'b1);
						parse_st = ST_GROUND;
					end else if (c == CH_DIG_2 || c == CH_DIG_3 || c == CH_DIG_5 || c == CH_DIG_6) begin
						held_digit = c;
						parse_st = ST_TILDE;
					end else begin
						replay_broken_sequence();
						take_ground_byte(c);
					end
				end
				ST_O: begin
					if ((c >= CH_FKEY_LO && c <= CH_FKEY_HI) || c == CH_HOME || c == CH_END) begin
						emit_key(c, 1'b1);
						parse_st = ST_GROUND;
					end else begin
						replay_broken_sequence();
						take_ground_byte(c);
					end
				end
				ST_TILDE: begin
					if (c == CH_TILDE) begin
						emit_key(held_digit, 1'b1);
						parse_st = ST_GROUND;
					end else begin
						replay_broken_sequence();
						take_ground_byte(c);
					end
				end
				default: begin
					parse_st = ST_GROUND;
					take_ground_byte(c);
				end
			endcase
		end
		foreach (step_events[i]) begin
			res.code = step_events[i].code;
			res.special = step_events[i].special;
			res.last = (i == step_events.size() - 1);
			expected_key_events.push_back(res);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		key_result_t want;
		if (!arst_n) begin
			cfg_enable = 1'b0;
			cfg_esc_code = RST_ESC_CODE;
			cfg_enter = RST_ENTER_CODE;
			cfg_tab = RST_TAB_CODE;
			cfg_bs = RST_BS_CODE;
			parse_st = ST_GROUND;
			held_digit = 8'd0;
			expected_key_events.delete();
			errors = 0;
		end else begin
			if (key_in.valid && key_in.ready)
				decode_key_transaction(key_in.cmd, key_in.key_byte);
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[AddrWidth-1:2]))
					REG_ENABLE:   cfg_enable = pwdata[0];
					REG_ESC_CODE: cfg_esc_code = pwdata[7:0];
					REG_ENTER:    cfg_enter = pwdata[7:0];
					REG_TAB:      cfg_tab = pwdata[7:0];
					REG_BS:       cfg_bs = pwdata[7:0];
					default: ;
				endcase
			end
			if (key_out.valid && key_out.ready) begin
				if (expected_key_events.size() == 0) begin
					if (errors < 10)
						$display("%t: key event code %0d special %0d last %0d with none expected",
							$realtime, key_out.key_code, key_out.special, key_out.last);
					errors++;
				end else begin
					want = expected_key_events.pop_front();
					if (key_out.key_code !== want.code || key_out.special !== want.special ||
							key_out.last !== want.last) begin
						if (errors < 10)
							$display("%t: key event mismatch: expected code %0d special %0d last %0d, got code %0d special %0d last %0d",
								$realtime, want.code, want.special, want.last,
								key_out.key_code, key_out.special, key_out.last);
						errors++;
					end
				end
			end
		end
		error_count <= errors;
		outstanding <= expected_key_events.size();
	end

endmodule

@@ tb/tb_ansi_escape_key_decoder.sv @@
`timescale 1ns / 1ps
// tb_ansi_escape_key_decoder: drives key bytes, timeouts and register writes into the
// decoder under several idle and stall patterns; key_event_checker does the checking
// depends on adk_pkg, key_in_if, key_out_if, key_event_checker and the decoder

module tb_ansi_escape_key_decoder;
	import adk_pkg::*;

	localparam int StallLimit  = 5000;
	localparam int DrainCycles = 12;
	localparam int HoldCycles  = 80;
	localparam int PhaseItems  = 42;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic                 pready;
	logic [AddrWidth-1:0] paddr;
	logic [DataWidth-1:0] pwdata;
	logic [DataWidth-1:0] prdata;
	int                   error_count;
	int                   outstanding;
	int                   send_idle_pct = 0;
	int                   recv_stall_pct = 0;
	bit                   long_hold_req = 1'b0;
	int                   quiet_cycles = 0;
	int                   sent = 0;
	logic [7:0]           cur_enter = RST_ENTER_CODE;
	logic [7:0]           cur_tab = RST_TAB_CODE;
	logic [7:0]           cur_bs = RST_BS_CODE;

	key_in_if  key_in();
	key_out_if key_out();

	ansi_escape_key_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.key_in  (key_in),
		.key_out (key_out),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	key_event_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.key_in      (key_in),
		.key_out     (key_out),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.error_count (error_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		key_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				key_out.ready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
			end
			key_out.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((key_in.valid && key_in.ready) || (key_out.valid && key_out.ready) ||
				(psel && penable))
			quiet_cycles <= 0;
		else if (quiet_cycles >= StallLimit) begin
			$display("simulation failed");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	task automatic send_key(input logic cmd, input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			key_in.valid <= 1'b0;
			@(negedge clk);
		end
		key_in.valid <= 1'b1;
		key_in.cmd <= cmd;
		key_in.key_byte <= b;
		do @(posedge clk); while (!key_in.ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic apply_settings(input logic en, input logic [7:0] esc, input logic [7:0] enter,
			input logic [7:0] tab, input logic [7:0] bs);
		logic [7:0] values[5];
		reg_idx_t   r;
		key_in.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
		values[REG_ENABLE] = {7'd0, en};
		values[REG_ESC_CODE] = esc;
		values[REG_ENTER] = enter;
		values[REG_TAB] = tab;
		values[REG_BS] = bs;
		r = r.first();
		do begin
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= {r, 2'b00};
			pwdata <= DataWidth'(values[r]);
			@(negedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			@(negedge clk);
			r = r.next();
		end while (r != r.first());
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_enter = enter;
		cur_tab = tab;
		cur_bs = bs;
	endtask

	task automatic send_random_sequence();
		int         kind;
		int         cut;
		logic [7:0] seq[$];
		logic [7:0] b;
		kind = $urandom_range(99);
		if (kind < 75) begin
			case ($urandom_range(2))
				0: seq = '{ESC_BYTE, CH_LBRACKET, 8'(CH_ARROW_LO + $urandom_range(3))};
				1: begin
					case ($urandom_range(3))
						0: b = CH_DIG_2;
						1: b = CH_DIG_3;
						2: b = CH_DIG_5;
						default: b = CH_DIG_6;
					endcase
					seq = '{ESC_BYTE, CH_LBRACKET, b, CH_TILDE};
				end
				default: begin
					case ($urandom_range(5))
						4: b = CH_HOME;
						5: b = CH_END;
						default: b = 8'(CH_FKEY_LO + $urandom_range(3));
					endcase
					seq = '{ESC_BYTE, CH_O, b};
				end
			endcase
			// broken sequence: a prefix, then a timeout or a stray byte
			if (kind >= 60) begin
				cut = $urandom_range(seq.size() - 1, 1);
				while (seq.size() > cut) seq.pop_back();
			end
			foreach (seq[i]) send_key(CMD_BYTE, seq[i]);
			if (kind >= 60) begin
				if ($urandom_range(1))
					send_key(CMD_TIMEOUT, 8'($urandom_range(255)));
				else
					send_key(CMD_BYTE, 8'($urandom_range(255)));
			end
		end else if (kind < 90) begin
			case ($urandom_range(7))
				0: b = cur_enter;
				1: b = cur_tab;
				2: b = cur_bs;
				3: b = ESC_BYTE;
				default: b = 8'($urandom_range(255));
			endcase
			send_key(CMD_BYTE, b);
		end else
			send_key(CMD_TIMEOUT, 8'($urandom_range(255)));
	endtask

	initial begin
		int start;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		key_in.valid = 1'b0;
		key_in.cmd = CMD_BYTE;
		key_in.key_byte = 8'd0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// handler off after reset: dropped, parser stays in ground
		send_key(CMD_BYTE, ESC_BYTE);
		send_key(CMD_BYTE, CH_LBRACKET);
		send_key(CMD_TIMEOUT, 8'hA5);
		apply_settings(1'b1, RST_ESC_CODE, RST_ENTER_CODE, RST_TAB_CODE, RST_BS_CODE);

		send_key(CMD_BYTE, 8'h00);
		send_key(CMD_BYTE, 8'hFF);
		send_key(CMD_BYTE, RST_ENTER_CODE);
		send_key(CMD_BYTE, RST_TAB_CODE);
		send_key(CMD_BYTE, RST_BS_CODE);
		send_key(CMD_BYTE, ESC_BYTE);
		send_key(CMD_BYTE, CH_LBRACKET);
		send_key(CMD_BYTE, CH_ARROW_LO);
		send_key(CMD_BYTE, ESC_BYTE);
		send_key(CMD_BYTE, CH_LBRACKET);
		send_key(CMD_BYTE, CH_DIG_6);
		send_key(CMD_BYTE, CH_TILDE);
		send_key(CMD_BYTE, ESC_BYTE);
		send_key(CMD_BYTE, CH_O);
		send_key(CMD_BYTE, CH_END);
		send_key(CMD_TIMEOUT, 8'h5A);
		send_key(CMD_BYTE, ESC_BYTE);
		send_key(CMD_BYTE, CH_LBRACKET);
		send_key(CMD_BYTE, CH_DIG_5);
		send_key(CMD_TIMEOUT, 8'hFF);
		// abort while waiting for the tilde, then escape starts a new sequence
		send_key(CMD_BYTE, ESC_BYTE);
		send_key(CMD_BYTE, CH_LBRACKET);
		send_key(CMD_BYTE, CH_DIG_3);
		send_key(CMD_BYTE, ESC_BYTE);
		send_key(CMD_TIMEOUT, 8'h00);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					apply_settings(1'b1, 8'h00, 8'hFF, 8'h00, ESC_BYTE);
					long_hold_req = 1'b1;
				end
				1: begin
					send_idle_pct = 77;
					recv_stall_pct = 0;
					apply_settings(1'b1, 8'hFF, RST_ENTER_CODE, RST_TAB_CODE, RST_BS_CODE);
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 77;
					// handler detached for a while, parser state must survive
					apply_settings(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)),
						8'($urandom_range(255)), 8'($urandom_range(255)));
					repeat (10) send_random_sequence();
					apply_settings(1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)),
						8'($urandom_range(255)), 8'($urandom_range(255)));
				end
				default: begin
					send_idle_pct = 16;
					recv_stall_pct = 16;
					apply_settings(1'b1, ESC_BYTE, ESC_BYTE, CH_ARROW_LO, CH_LBRACKET);
				end
			endcase
			start = sent;
			while (sent - start < PhaseItems) send_random_sequence();
		end

		key_in.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
		if (outstanding != 0)
			$display("%0d key events never arrived", outstanding);
		if (error_count == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
